// ===== rtl/bb3_pkg.sv =====
// Shared types, constants and helpers of the 3x3 box blur.
package bb3_pkg;

  localparam int MaxWidthDefault  = 4096;
  localparam int MaxHeightDefault = 4096;

  localparam int CfgIdxWidth  = 4;
  localparam int CfgDataWidth = 13;

  localparam logic [CfgDataWidth-1:0] FrameWidthReset  = 13'd1024;
  localparam logic [CfgDataWidth-1:0] FrameHeightReset = 13'd1024;

  // floor(s / 9) equals (s * 1821) >> 14 for every s up to 9 * 255.
  localparam logic [10:0] Div9Mul = 11'd1821;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgFrameWidth  = 4'd0,
    CfgFrameHeight = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] pixel_alpha;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  blur_alpha;
    logic [7:0]  blur_red;
    logic [7:0]  blur_green;
    logic [7:0]  blur_blue;
    logic [11:0] out_column;
    logic [11:0] out_row;
    logic        last_of_run;
  } blur_t;

  // Position of a pixel relative to the frame edges.
  typedef struct packed {
    logic c_ge1;
    logic c_ge2;
    logic c_last;
    logic r_ge1;
    logic r_ge2;
    logic r_last;
  } pos_flags_t;

  // Per channel vertical sums of one column; element 3 is alpha.
  typedef logic [3:0][9:0]  col_sum_t;
  // Four candidate results, four channels each.
  typedef logic [3:0][3:0][11:0] res_sums_t;

  function automatic logic [7:0] div9(input logic [11:0] s);
    logic [21:0] p;
    p = 22'(s) * 22'(Div9Mul);
    return p[21:14];
  endfunction

endpackage

// ===== rtl/box_blur_3x3_edge_clamped_unit.sv =====
// 3x3 box blur, edge clamped: pixels pass stage 1, the bank and the output register.
// Throughput: one pixel per cycle while each pixel releases at most one result and the
// output is not stalled; a pixel that releases n results (up to four) holds the input,
// one result per beat out of the single output register. Reset sets a 1024x1024 frame and
// row 0, column 0; the two line-store RAMs are not cleared and need no clearing pass.
module box_blur_3x3_edge_clamped_unit
  import bb3_pkg::*;
#(
  parameter int MaxWidth  = MaxWidthDefault,
  parameter int MaxHeight = MaxHeightDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pixel_t                  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output blur_t                   out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int CW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;

  function automatic logic [CW-1:0] width_last(input logic [CfgDataWidth-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) r = '0;
    else if (32'(v) > 32'(MaxWidth)) r = CW'(MaxWidth - 1);
    else r = CW'(v - 1'b1);
    return r;
  endfunction

  function automatic logic [RW-1:0] height_last(input logic [CfgDataWidth-1:0] v);
    logic [RW-1:0] r;
    if (v == '0) r = '0;
    else if (32'(v) > 32'(MaxHeight)) r = RW'(MaxHeight - 1);
    else r = RW'(v - 1'b1);
    return r;
  endfunction

  // Frame geometry and raster position of the next pixel.
  logic [CW-1:0] w_last_q, col_q, col_d;
  logic [RW-1:0] h_last_q, row_q, row_d;
  logic          in_accept;
  pos_flags_t    in_flags;

  // Stage 1: pixel waiting for its line-store data.
  logic          p1_valid_q, p1_fire;
  pixel_t        p1_pix_q;
  logic [CW-1:0] p1_col_q;
  logic [RW-1:0] p1_row_q;
  pos_flags_t    p1_flags_q;
  logic          p1_fwd_q;
  logic [31:0]   fwd_prev_q, fwd_older_q;
  logic [31:0]   prev_rd, older_rd, prev_eff, older_eff;
  logic [31:0]   t0, t1, t2;
  col_sum_t      u_cur, l_cur;
  col_sum_t      win0_u_q, win0_l_q, win1_u_q, win1_l_q;
  res_sums_t     p1_sums;
  logic [3:0]    p1_mask;

  // Result bank and output register.
  res_sums_t     bank_sums_q;
  logic [3:0]    bank_mask_q, rest_mask;
  logic [CW-1:0] bank_col_q;
  logic [RW-1:0] bank_row_q;
  logic [1:0]    sel;
  logic          out_load_ok, emit, bank_take, emit_last;
  logic          out_valid_q;
  blur_t         out_q;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  assign in_flags.c_ge1  = col_q != '0;
  assign in_flags.c_ge2  = col_q > CW'(1);
  assign in_flags.c_last = col_q == w_last_q;
  assign in_flags.r_ge1  = row_q != '0;
  assign in_flags.r_ge2  = row_q > RW'(1);
  assign in_flags.r_last = row_q == h_last_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_flags.c_last) begin
      col_d = '0;
      row_d = in_flags.r_last ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= width_last(FrameWidthReset);
      h_last_q <= height_last(FrameHeightReset);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgFrameWidth: begin
          w_last_q <= width_last(cfg_data_i);
          col_q    <= '0;
          row_q    <= '0;
        end
        CfgFrameHeight: begin
          h_last_q <= height_last(cfg_data_i);
          col_q    <= '0;
          row_q    <= '0;
        end
        default: ;
      endcase
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  bb3_ram #(.Width(32), .Depth(MaxWidth)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (p1_fire),
    .waddr_i (p1_col_q),
    .wdata_i (p1_pix_q),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (prev_rd)
  );

  bb3_ram #(.Width(32), .Depth(MaxWidth)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (p1_fire),
    .waddr_i (p1_col_q),
    .wdata_i (prev_eff),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (older_rd)
  );

  // A read issued in the same cycle as a write to the same column sees the old
  // entry, so the written values are forwarded instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (in_accept) begin
      p1_valid_q <= 1'b1;
    end else if (p1_fire) begin
      p1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p1_pix_q    <= in_data_i;
      p1_col_q    <= col_q;
      p1_row_q    <= row_q;
      p1_flags_q  <= in_flags;
      p1_fwd_q    <= p1_valid_q && (p1_col_q == col_q);
      fwd_prev_q  <= p1_pix_q;
      fwd_older_q <= prev_eff;
    end
  end

  assign prev_eff  = p1_fwd_q ? fwd_prev_q : prev_rd;
  assign older_eff = p1_fwd_q ? fwd_older_q : older_rd;
  assign t2 = p1_pix_q;
  assign t1 = p1_flags_q.r_ge1 ? prev_eff : t2;
  assign t0 = p1_flags_q.r_ge2 ? older_eff : t1;

  always_comb begin
    logic [9:0] lft_u, lft_l, end_u, end_l;
    for (int i = 0; i < 4; i++) begin
      u_cur[i] = 10'(t0[8*i +: 8]) + 10'(t1[8*i +: 8]) + 10'(t2[8*i +: 8]);
      l_cur[i] = 10'(t1[8*i +: 8]) + {1'b0, t2[8*i +: 8], 1'b0};
      lft_u = p1_flags_q.c_ge2 ? win1_u_q[i] : win0_u_q[i];
      lft_l = p1_flags_q.c_ge2 ? win1_l_q[i] : win0_l_q[i];
      end_u = p1_flags_q.c_ge1 ? win0_u_q[i] : u_cur[i];
      end_l = p1_flags_q.c_ge1 ? win0_l_q[i] : l_cur[i];
      p1_sums[0][i] = 12'(lft_u) + 12'(win0_u_q[i]) + 12'(u_cur[i]);
      p1_sums[1][i] = 12'(end_u) + {1'b0, u_cur[i], 1'b0};
      p1_sums[2][i] = 12'(lft_l) + 12'(win0_l_q[i]) + 12'(l_cur[i]);
      p1_sums[3][i] = 12'(end_l) + {1'b0, l_cur[i], 1'b0};
    end
  end

  assign p1_mask[0] = p1_flags_q.r_ge1 && p1_flags_q.c_ge1;
  assign p1_mask[1] = p1_flags_q.r_ge1 && p1_flags_q.c_last;
  assign p1_mask[2] = p1_flags_q.r_last && p1_flags_q.c_ge1;
  assign p1_mask[3] = p1_flags_q.r_last && p1_flags_q.c_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_u_q <= '0;
      win0_l_q <= '0;
      win1_u_q <= '0;
      win1_l_q <= '0;
    end else if (p1_fire) begin
      win1_u_q <= win0_u_q;
      win1_l_q <= win0_l_q;
      win0_u_q <= u_cur;
      win0_l_q <= l_cur;
    end
  end

  // The bank hands out its results in raster order, one per output beat.
  always_comb begin
    if (bank_mask_q[0]) sel = 2'd0;
    else if (bank_mask_q[1]) sel = 2'd1;
    else if (bank_mask_q[2]) sel = 2'd2;
    else sel = 2'd3;
  end

  assign rest_mask   = bank_mask_q & ~(4'b0001 << sel);
  assign emit_last   = rest_mask == '0;
  assign out_load_ok = !out_valid_q || out_ready_i;
  assign emit        = (bank_mask_q != '0) && out_load_ok;
  assign bank_take   = (bank_mask_q == '0) || (emit && emit_last);
  assign p1_fire     = p1_valid_q && bank_take;
  assign in_ready_o  = !p1_valid_q || p1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_mask_q <= '0;
    end else if (p1_fire) begin
      bank_mask_q <= p1_mask;
    end else if (emit) begin
      bank_mask_q <= rest_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_fire) begin
      bank_sums_q <= p1_sums;
      bank_col_q  <= p1_col_q;
      bank_row_q  <= p1_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.blur_alpha  <= div9(bank_sums_q[sel][3]);
      out_q.blur_red    <= div9(bank_sums_q[sel][2]);
      out_q.blur_green  <= div9(bank_sums_q[sel][1]);
      out_q.blur_blue   <= div9(bank_sums_q[sel][0]);
      out_q.out_column  <= 12'(sel[0] ? bank_col_q : bank_col_q - 1'b1);
      out_q.out_row     <= 12'(sel[1] ? bank_row_q : bank_row_q - 1'b1);
      out_q.last_of_run <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Forwarding is only ever needed when the frame is one column wide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q && p1_fwd_q |-> w_last_q == '0)
    else $error("line-store forwarding hit with a frame wider than one column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last_q && row_q <= h_last_q)
    else $error("raster position outside the configured frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_fire |=> bank_mask_q == $past(p1_mask))
    else $error("result bank did not take the released results");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_mask_q != '0 |-> p1_valid_q || !in_ready_o || bank_take || !emit_last || !emit)
    else $error("pixel stage left while the bank still holds results");

endmodule

// ===== rtl/bb3_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bb3_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/tb_box_blur_3x3_edge_clamped_unit.sv =====
// Self-checking testbench of the edge-clamped 3x3 box blur unit.
module tb_box_blur_3x3_edge_clamped_unit;
  import bb3_pkg::*;

  localparam int ItemTarget   = 430;
  localparam int SettleCycles = 8;
  localparam int StallLimit   = 2000;
  localparam int PrintLimit   = 200;
  localparam int BoxTaps      = 9;
  localparam int LastCfgIndex = 2 ** CfgIdxWidth - 1;

  // Rows r-2, r-1 and r of one column, vertically clamped.
  typedef logic [2:0][31:0] column_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  pixel_t                  in_data = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  blur_t                   out_data_o;
  logic                    cfg_ready_o;

  // Shadow copy of the unit's frame state.
  logic [CfgDataWidth-1:0] frame_w = FrameWidthReset;
  logic [CfgDataWidth-1:0] frame_h = FrameHeightReset;
  logic [31:0]             older_row [MaxWidthDefault];
  logic [31:0]             prev_row [MaxWidthDefault];
  column_t                 win_col [2] = '{default: '0};
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;

  blur_t       expected_blurs [$];
  int unsigned mismatches = 0;
  int unsigned sent_pixels = 0;
  int unsigned quiet_cycles = 0;
  int unsigned out_stall = 0;
  bit          quiet = 1'b0;

  box_blur_3x3_edge_clamped_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [CfgDataWidth-1:0] v,
                                            input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic blur_t box_mean(input column_t lc, input column_t mc, input column_t rc,
                                     input bit bottom_row, input int unsigned col,
                                     input int unsigned row);
    blur_t           res;
    logic [3:0][7:0] mean;
    int unsigned     total, ch, j, k;
    for (ch = 0; ch < 4; ch++) begin
      total = 0;
      for (j = 0; j < 3; j++) begin
        // On the last row the row below is the last row itself.
        k = bottom_row ? ((j == 0) ? 1 : 2) : j;
        total += lc[k][8*ch +: 8] + mc[k][8*ch +: 8] + rc[k][8*ch +: 8];
      end
      mean[ch] = 8'(total / BoxTaps);
    end
    {res.blur_alpha, res.blur_red, res.blur_green, res.blur_blue} = mean;
    res.out_column  = 12'(col);
    res.out_row     = 12'(row);
    res.last_of_run = 1'b0;
    return res;
  endfunction

  // Works out the results that one accepted pixel releases and advances the position.
  task automatic predict_blur(input pixel_t px);
    int unsigned w, h, c, r, n, i;
    column_t     cur, lft, lft_end;
    blur_t       res [4];
    w = clamp_dim(frame_w, MaxWidthDefault);
    h = clamp_dim(frame_h, MaxHeightDefault);
    c = col_pos;
    r = row_pos;
    n = 0;
    cur[2] = px;
    cur[1] = (r >= 1) ? prev_row[c] : cur[2];
    cur[0] = (r >= 2) ? older_row[c] : cur[1];
    lft     = (c >= 2) ? win_col[1] : win_col[0];
    lft_end = (c >= 1) ? win_col[0] : cur;
    if (r >= 1) begin
      if (c >= 1) begin
        res[n] = box_mean(lft, win_col[0], cur, 1'b0, c - 1, r - 1);
        n++;
      end
      if (c == w - 1) begin
        res[n] = box_mean(lft_end, cur, cur, 1'b0, c, r - 1);
        n++;
      end
    end
    if (r == h - 1) begin
      if (c >= 1) begin
        res[n] = box_mean(lft, win_col[0], cur, 1'b1, c - 1, r);
        n++;
      end
      if (c == w - 1) begin
        res[n] = box_mean(lft_end, cur, cur, 1'b1, c, r);
        n++;
      end
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) expected_blurs = {expected_blurs, res[i]};
    older_row[c] = prev_row[c];
    prev_row[c]  = cur[2];
    win_col[1]   = win_col[0];
    win_col[0]   = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < PrintLimit) $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  function automatic string fmt_blur(input blur_t b);
    return $sformatf("argb=%02h/%02h/%02h/%02h col=%0d row=%0d last=%0d", b.blur_alpha,
                     b.blur_red, b.blur_green, b.blur_blue, b.out_column, b.out_row,
                     b.last_of_run);
  endfunction

  task automatic check_blur(input blur_t got);
    blur_t want;
    string bad;
    if (expected_blurs.size() == 0) begin
      report_mismatch({"unexpected result ", fmt_blur(got)});
      return;
    end
    want = expected_blurs.pop_front();
    bad = "";
    if (got.blur_alpha !== want.blur_alpha) bad = {bad, " alpha"};
    if (got.blur_red !== want.blur_red) bad = {bad, " red"};
    if (got.blur_green !== want.blur_green) bad = {bad, " green"};
    if (got.blur_blue !== want.blur_blue) bad = {bad, " blue"};
    if (got.out_column !== want.out_column) bad = {bad, " column"};
    if (got.out_row !== want.out_row) bad = {bad, " row"};
    if (got.last_of_run !== want.last_of_run) bad = {bad, " last"};
    if (bad != "") report_mismatch({"wrong", bad, ": got ", fmt_blur(got), " want ",
                                    fmt_blur(want)});
  endtask

  // Results are checked before the pixel of the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && out_ready) check_blur(out_data_o);
      if (in_valid && in_ready_o) predict_blur(in_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stalls at random; no new stall starts while the quiet flag is set.
  initial begin
    forever begin
      @(negedge clk);
      if (out_stall > 0) begin
        out_ready = 1'b0;
        out_stall--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  // Called and returns at a falling edge; valid stays high after the beat.
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (!in_ready_o);
    sent_pixels++;
    @(negedge clk);
  endtask

  // Lets every expected result arrive, then covers pixels that release nothing.
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_blurs.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready_o);
    if (idx == CfgFrameWidth || idx == CfgFrameHeight) begin
      if (idx == CfgFrameWidth) frame_w = value;
      else frame_h = value;
      col_pos = 0;
      row_pos = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_reset_size();
    int unsigned i;
    // Row 0 of a 1024-row frame releases no result.
    for (i = 0; i < 3; i++) send_pixel(pixel_t'($urandom));
  endtask

  task automatic test_small_frame_extremes();
    logic [31:0] pattern [9] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF,
                                 32'hFF00_FF00, 32'h0102_0304, 32'hFFFF_FFFF,
                                 32'h8080_8080, 32'h7F7F_7F7F, 32'hFFFF_FFFF};
    int unsigned i;
    write_cfg(CfgFrameWidth, 13'd3);
    write_cfg(CfgFrameHeight, 13'd3);
    for (i = 0; i < 9; i++) begin
      send_pixel(pixel_t'(pattern[i]));
      // An unknown index must neither change the size nor restart the frame.
      if (i == 3)
        write_cfg(CfgIdxWidth'($urandom_range(CfgFrameHeight + 1, LastCfgIndex)),
                  CfgDataWidth'($urandom));
    end
  endtask

  task automatic test_size_limits();
    int unsigned i;
    // Zero sizes are taken as one: every pixel is a whole frame.
    write_cfg(CfgFrameWidth, '0);
    write_cfg(CfgFrameHeight, '0);
    for (i = 0; i < 2; i++) send_pixel(pixel_t'($urandom));
    // Oversized width clamps to the maximum, single row.
    write_cfg(CfgFrameWidth, '1);
    write_cfg(CfgFrameHeight, 13'd1);
    for (i = 0; i < 4; i++) send_pixel(pixel_t'($urandom));
    // One column, oversized height.
    write_cfg(CfgFrameWidth, 13'd1);
    write_cfg(CfgFrameHeight, '1);
    for (i = 0; i < 4; i++) send_pixel(pixel_t'($urandom));
  endtask

  task automatic test_random_frames();
    int unsigned kind, w, h, count, i;
    while (sent_pixels < ItemTarget) begin
      quiet = ($urandom_range(0, 4) == 0);
      kind  = $urandom_range(0, 9);
      if (kind == 0) begin
        w = $urandom_range(MaxWidthDefault, 8191);
        h = $urandom_range(1, 3);
      end else if (kind == 1) begin
        w = $urandom_range(1, 4);
        h = $urandom_range(MaxHeightDefault, 8191);
      end else begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 7);
      end
      write_cfg(CfgFrameWidth, CfgDataWidth'(w));
      write_cfg(CfgFrameHeight, CfgDataWidth'(h));
      // Full frames mostly, sometimes cut short by the next size change.
      if (kind <= 1) count = $urandom_range(5, 20);
      else begin
        count = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w * h);
      end
      for (i = 0; i < count && sent_pixels < ItemTarget; i++) begin
        send_pixel(pixel_t'($urandom));
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_size();
    test_small_frame_extremes();
    test_size_limits();
    test_random_frames();
    drain_results();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
